// ----- hdl/sorted_multiset_counter_assert.svh -----
// assertion macros for the sorted multiset counter checker
`ifndef SORTED_MULTISET_COUNTER_ASSERT_SVH
`define SORTED_MULTISET_COUNTER_ASSERT_SVH

// implication in the same cycle
`define SMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle
`define SMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/smc_pkg.sv -----
// package for the sorted multiset counter: widths, codes and defaults
`timescale 1ns / 1ps
package smc_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int OPCODE_W   = 2;
    localparam int VALUE_W    = 32;
    localparam int AMOUNT_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int REMOVED_W  = 16;
    localparam int FREQ_W     = 16;
    localparam int TOTAL_W    = 22;
    localparam int DISTINCT_W = 7;

    localparam int S_TUSER_W = OPCODE_W;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;

    // result field offsets in the master tdata
    localparam int STATUS_LSB   = 0;
    localparam int REMOVED_LSB  = STATUS_LSB + STATUS_W;
    localparam int FREQ_LSB     = REMOVED_LSB + REMOVED_W;
    localparam int TOTAL_LSB    = FREQ_LSB + FREQ_W;
    localparam int DISTINCT_LSB = TOTAL_LSB + TOTAL_W;
    localparam int RESULT_W     = DISTINCT_LSB + DISTINCT_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DOWN,
        S_OUT
    } t_state;

endpackage

// ----- hdl/sorted_multiset_counter.sv -----
// sorted multiset counter: ordered value/count table in one memory
// an item passes the scan of occupied entries, a decide step, a shift and a put for an insert,
// a shift for a remove that drops an entry, and then the output register
// throughput: one item at a time; the scan and the shift each take one memory access a cycle
// the next input is taken once the result sits in the output register
// reset clears occupancy, total and handshakes; table memory is not cleared
`timescale 1ns / 1ps
module sorted_multiset_counter #(
    parameter int CAPACITY    = smc_pkg::DEF_CAPACITY,
    parameter int COUNT_WIDTH = smc_pkg::DEF_COUNT_WIDTH,
    parameter int VALUE_WIDTH = smc_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // value [31:0], amount [47:32]
    input  logic [smc_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // opcode [1:0]
    input  logic [smc_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // status [1:0], removed [17:2], frequency [33:18], total [55:34], distinct [62:56], zero [63]
    output logic [smc_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import smc_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int OW = $clog2(CAPACITY + 1);
    localparam int CW = COUNT_WIDTH;
    localparam int VW = VALUE_WIDTH;
    localparam int EW = VW + CW;
    localparam int XW = (CW > AMOUNT_W) ? CW : AMOUNT_W;

    t_state n_state;
    t_state r_state;

    t_opcode            r_op;
    logic [VW-1:0]      r_val;
    logic [AMOUNT_W-1:0] r_amt;
    logic [OW-1:0]      r_idx;
    logic [OW-1:0]      r_pos;
    logic               r_found;
    logic [CW-1:0]      r_cur_cnt;
    logic [OW-1:0]      r_occ;
    logic [TOTAL_W-1:0] r_total;
    t_status            r_status;
    logic [REMOVED_W-1:0] r_removed;
    logic [FREQ_W-1:0]  r_freq;
    logic               r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] r_rdata;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic                 s_accept;
    logic                 out_load;
    logic [VW+VALUE_W-1:0] in_val_ext;
    logic [VW-1:0]        rd_val;
    logic [CW-1:0]        rd_cnt;
    logic                 key_less;
    logic                 key_equal;
    logic [OW-1:0]        idx_inc;
    logic [OW-1:0]        idx_dec;
    logic [OW-1:0]        idx_m2;
    logic [OW-1:0]        idx_p2;
    logic [OW-1:0]        pos_inc;
    logic [OW-1:0]        occ_dec;
    logic                 cnt_saturated;
    logic [XW-1:0]        amt_x;
    logic [XW-1:0]        cnt_x;
    logic [XW-1:0]        left_x;
    logic                 drop_entry;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign out_load        = (r_state == S_OUT) && (!r_m_valid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // value field widened or cut to the stored width
    assign in_val_ext = {{VW{1'b0}}, i_s_axis_tdata[VALUE_W-1:0]};

    assign rd_val        = r_rdata[EW-1:CW];
    assign rd_cnt        = r_rdata[CW-1:0];
    assign key_less      = $signed(rd_val) < $signed(r_val);
    assign key_equal     = (rd_val == r_val);
    assign idx_inc       = r_idx + OW'(1);
    assign idx_dec       = r_idx - OW'(1);
    assign idx_m2        = r_idx - OW'(2);
    assign idx_p2        = r_idx + OW'(2);
    assign pos_inc       = r_pos + OW'(1);
    assign occ_dec       = r_occ - OW'(1);
    assign cnt_saturated = (r_cur_cnt == {CW{1'b1}});
    assign amt_x         = XW'(r_amt);
    assign cnt_x         = XW'(r_cur_cnt);
    assign left_x        = cnt_x - amt_x;
    assign drop_entry    = (amt_x >= cnt_x);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = (r_occ == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!(key_less && (idx_inc != r_occ))) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_OUT;
                priority case (r_op)
                    OP_ADD: begin
                        if (!r_found && (r_occ != OW'(CAPACITY))) begin
                            n_state = (r_pos == r_occ) ? S_PUT : S_SHIFT_UP;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_found && drop_entry && (pos_inc != r_occ)) begin
                            n_state = S_SHIFT_DOWN;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_SHIFT_UP: begin
                if (idx_dec == r_pos) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: n_state = S_OUT;
            S_SHIFT_DOWN: begin
                // occupancy is already decremented here
                if (!(idx_inc < r_occ)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control; in the decide state a read and a write can address the same entry
    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_pos[AW-1:0];
        wr_data = {r_val, CW'(1)};
        unique case (r_state)
            S_IDLE: rd_addr = '0;
            S_SCAN: rd_addr = idx_inc[AW-1:0];
            S_DECIDE: begin
                rd_addr = (r_op == OP_ADD) ? occ_dec[AW-1:0] : pos_inc[AW-1:0];
                if (r_op == OP_ADD && r_found && !cnt_saturated) begin
                    wr_en   = 1'b1;
                    wr_data = {r_val, r_cur_cnt + CW'(1)};
                end else if (r_op == OP_REMOVE && r_found && !drop_entry) begin
                    wr_en   = 1'b1;
                    wr_data = {r_val, CW'(left_x)};
                end
            end
            S_SHIFT_UP: begin
                rd_addr = idx_m2[AW-1:0];
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                wr_data = r_rdata;
            end
            S_PUT: wr_en = 1'b1;
            S_SHIFT_DOWN: begin
                rd_addr = idx_p2[AW-1:0];
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                wr_data = r_rdata;
            end
            S_OUT: rd_addr = '0;
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_total   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECIDE && r_found) begin
                if (r_op == OP_ADD && !cnt_saturated) begin
                    r_total <= r_total + TOTAL_W'(1);
                end else if (r_op == OP_REMOVE) begin
                    if (drop_entry) begin
                        r_total <= r_total - TOTAL_W'(r_cur_cnt);
                        r_occ   <= occ_dec;
                    end else begin
                        r_total <= r_total - TOTAL_W'(r_amt);
                    end
                end
            end
            if (r_state == S_PUT) begin
                r_occ   <= r_occ + OW'(1);
                r_total <= r_total + TOTAL_W'(1);
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // item payload, scan position and result fields
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    r_op    <= t_opcode'(i_s_axis_tuser);
                    r_val   <= in_val_ext[VW-1:0];
                    r_amt   <= i_s_axis_tdata[VALUE_W +: AMOUNT_W];
                    r_idx   <= '0;
                    r_pos   <= '0;
                    r_found <= 1'b0;
                end
            end
            S_SCAN: begin
                if (key_less) begin
                    r_idx <= idx_inc;
                    r_pos <= idx_inc;
                end else begin
                    r_pos     <= r_idx;
                    r_found   <= key_equal;
                    r_cur_cnt <= rd_cnt;
                end
            end
            S_DECIDE: begin
                r_status  <= ST_DONE;
                r_removed <= '0;
                r_freq    <= '0;
                priority case (r_op)
                    OP_ADD: begin
                        if (r_found) begin
                            if (cnt_saturated) begin
                                r_status <= ST_SATURATED;
                                r_freq   <= FREQ_W'(r_cur_cnt);
                            end else begin
                                r_freq <= FREQ_W'(r_cur_cnt + CW'(1));
                            end
                        end else if (r_occ == OW'(CAPACITY)) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_freq <= FREQ_W'(1);
                            r_idx  <= r_occ;
                        end
                    end
                    OP_REMOVE: begin
                        if (!r_found) begin
                            r_status <= ST_ABSENT;
                        end else if (drop_entry) begin
                            r_removed <= REMOVED_W'(r_cur_cnt);
                            r_idx     <= r_pos;
                        end else begin
                            r_removed <= r_amt;
                            r_freq    <= FREQ_W'(left_x);
                        end
                    end
                    default: begin
                        if (r_found) begin
                            r_freq <= FREQ_W'(r_cur_cnt);
                        end else begin
                            r_status <= ST_ABSENT;
                        end
                    end
                endcase
            end
            S_SHIFT_UP:   r_idx <= idx_dec;
            S_SHIFT_DOWN: r_idx <= idx_inc;
            S_PUT:        r_idx <= r_idx;
            S_OUT: begin
                if (out_load) begin
                    r_m_data <= {{(M_TDATA_W - RESULT_W){1'b0}}, DISTINCT_W'(r_occ), r_total,
                                 r_freq, r_removed, r_status};
                end
            end
            default: r_idx <= r_idx;
        endcase
    end

endmodule

// ----- hdl/smc_checker.sv -----
// port-level checker for the sorted multiset counter, bound to the top level
`timescale 1ns / 1ps
`include "sorted_multiset_counter_assert.svh"
module smc_checker #(
    parameter int CAPACITY = smc_pkg::DEF_CAPACITY
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [smc_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import smc_pkg::*;

    logic [STATUS_W-1:0]   res_status;
    logic [REMOVED_W-1:0]  res_removed;
    logic [FREQ_W-1:0]     res_freq;
    logic [DISTINCT_W-1:0] res_distinct;

    assign res_status   = o_m_axis_tdata[STATUS_LSB +: STATUS_W];
    assign res_removed  = o_m_axis_tdata[REMOVED_LSB +: REMOVED_W];
    assign res_freq     = o_m_axis_tdata[FREQ_LSB +: FREQ_W];
    assign res_distinct = o_m_axis_tdata[DISTINCT_LSB +: DISTINCT_W];

    // one item in flight: input closes right after a transfer
    `SMC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input ready right after a transfer")

    `SMC_ASSERT_NOW(a_distinct_bound, i_clk, i_rst_n, o_m_axis_tvalid, 32'(res_distinct) <= 32'(CAPACITY), "distinct count above capacity")

    // refused or missing values report nothing removed and no count
    `SMC_ASSERT_NOW(a_no_count_on_miss, i_clk, i_rst_n, o_m_axis_tvalid && (res_status == ST_FULL || res_status == ST_ABSENT), res_removed == '0 && res_freq == '0, "count reported for a refused or absent value")

    `SMC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

endmodule

bind sorted_multiset_counter smc_checker #(
    .CAPACITY(CAPACITY)
) u_smc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
